/* sv/stick_radial_dead_zone_macros.svh */
// Assertion macros for the stick radial dead zone block.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef STICK_RADIAL_DEAD_ZONE_MACROS_SVH
`define STICK_RADIAL_DEAD_ZONE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRDZ_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRDZ_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* sv/srdz_pkg.sv */
// Shared types and constants for the stick radial dead zone block.
// No dependencies; used by the cell modules and the top level.
`default_nettype none

package srdz_pkg;

	localparam int RAW_W    = 16;
	localparam int BASE_W   = 19;
	localparam int DZ_W     = 15;
	localparam int MAG_W    = 24;
	localparam int SQ_N_W   = 48;
	localparam int SQ_REM_W = 26;
	localparam int SQ_STEPS = 24;
	localparam int DEN_W    = 39;
	localparam int OUT_MAX  = 262143;
	localparam int OUT_MIN  = -262144;

	localparam logic [DZ_W-1:0] FULL_SCALE   = 15'd32767;
	localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
	localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_LEFT_DZ  = 1'b0,
		REG_RIGHT_DZ = 1'b1
	} reg_idx_t;

	// State handed from one square root cell to the next.
	typedef struct packed {
		logic [SQ_N_W-1:0]   n;
		logic [SQ_REM_W-1:0] rem;
		logic [MAG_W-1:0]    root;
	} sq_t;

	// Per-item side data that rides along the whole pipeline.
	typedef struct packed {
		logic signed [BASE_W-1:0] bx;
		logic signed [BASE_W-1:0] by;
		logic                     sel;
		logic                     en;
		logic                     neg_x;
		logic                     neg_y;
		logic                     outside;
		logic [DZ_W-1:0]          dz;
		logic [RAW_W-1:0]         ax;
		logic [RAW_W-1:0]         ay;
	} side_t;

endpackage

`default_nettype wire

/* sv/srdz_sqrt_cell.sv */
// One cell of the square root chain: resolves one root bit per cycle while adv is high.
// Depends on srdz_pkg for the cell state type.
`default_nettype none

module srdz_sqrt_cell import srdz_pkg::*; (
	input  wire logic clk,
	input  wire logic adv,
	input  wire sq_t  sq_i,
	output sq_t       sq_o
);

	logic [SQ_REM_W+1:0] cand;
	logic [SQ_REM_W+1:0] trial;
	logic                ge;
	sq_t                 nxt;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		cand  = {sq_i.rem, sq_i.n[SQ_N_W-1 -: 2]};
		trial = {2'b00, sq_i.root, 2'b01};
		ge    = (cand >= trial);
		nxt.n    = {sq_i.n[SQ_N_W-3:0], 2'b00};
		nxt.rem  = ge ? SQ_REM_W'(cand - trial) : SQ_REM_W'(cand);
		nxt.root = {sq_i.root[MAG_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_o <= nxt;
		end
	end

endmodule

`default_nettype wire

/* sv/srdz_div_cell.sv */
// One cell of the divider chain: one quotient bit per cycle for both lanes while adv is high.
// Depends on srdz_pkg for the denominator width.
`default_nettype none

module srdz_div_cell import srdz_pkg::*; #(
	parameter int QW = 16
) (
	input  wire logic             clk,
	input  wire logic             adv,
	input  wire logic [DEN_W-1:0] den_i,
	input  wire logic [DEN_W-1:0] rem_x_i,
	input  wire logic [DEN_W-1:0] rem_y_i,
	input  wire logic [QW-1:0]    low_x_i,
	input  wire logic [QW-1:0]    low_y_i,
	input  wire logic [QW-1:0]    q_x_i,
	input  wire logic [QW-1:0]    q_y_i,
	output logic      [DEN_W-1:0] den_o,
	output logic      [DEN_W-1:0] rem_x_o,
	output logic      [DEN_W-1:0] rem_y_o,
	output logic      [QW-1:0]    low_x_o,
	output logic      [QW-1:0]    low_y_o,
	output logic      [QW-1:0]    q_x_o,
	output logic      [QW-1:0]    q_y_o
);

	logic [DEN_W:0] cand_x;
	logic [DEN_W:0] cand_y;
	logic           ge_x;
	logic           ge_y;

	// Shift in the next dividend bit and subtract where it fits.
	always_comb begin
		cand_x = {rem_x_i, low_x_i[QW-1]};
		cand_y = {rem_y_i, low_y_i[QW-1]};
		ge_x   = (cand_x >= {1'b0, den_i});
		ge_y   = (cand_y >= {1'b0, den_i});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_o   <= den_i;
			rem_x_o <= ge_x ? DEN_W'(cand_x - {1'b0, den_i}) : DEN_W'(cand_x);
			rem_y_o <= ge_y ? DEN_W'(cand_y - {1'b0, den_i}) : DEN_W'(cand_y);
			low_x_o <= {low_x_i[QW-2:0], 1'b0};
			low_y_o <= {low_y_i[QW-2:0], 1'b0};
			q_x_o   <= {q_x_i[QW-2:0], ge_x};
			q_y_o   <= {q_y_i[QW-2:0], ge_y};
		end
	end

endmodule

`default_nettype wire

/* sv/stick_radial_dead_zone.sv */
// Top level of the stick radial dead zone block.
// Depends on srdz_pkg, srdz_sqrt_cell, srdz_div_cell and the assertion macro header.
`default_nettype none

// Takes one stick reading per cycle while not stalled and returns one result per
// reading, in order. A square register and a sum register, a chain of 24 square root
// cells giving one magnitude bit each, the scale term registers, a chain of
// FRAC_BITS + 1 divider cells giving one quotient bit each, and the output register
// that applies sign, base and saturation follow one another. New readings keep
// entering while a result waits at the output, as long as the stage in front of the
// output register is empty. Dead-zone registers may be written only while idle.
module stick_radial_dead_zone import srdz_pkg::*; #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [14:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// raw_x[15:0], raw_y[31:16], base_x[50:32], base_y[69:51], zero fill
	input  wire logic [71:0] s_tdata,
	// stick_select[0], enable[1]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_x[18:0], out_y[37:19], zero fill
	output logic [39:0]      m_tdata,
	// deflected[0]
	output logic [0:0]       m_tuser
);

	localparam int QW    = FRAC_BITS + 1;
	localparam int NW    = DEN_W + FRAC_BITS + 1;
	localparam int P     = 29 + QW;
	localparam int LAST  = P - 1;
	localparam int SW    = ((QW + 1 > BASE_W) ? QW + 1 : BASE_W) + 1;
	localparam int ONE_Q = 1 << FRAC_BITS;
	localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

	logic [DZ_W-1:0] left_dz_q;
	logic [DZ_W-1:0] right_dz_q;

	logic [P-1:0] vld_q;
	side_t        cr_q [P];
	side_t        cr1_d;
	logic         out_vld_q;
	logic         out_hold;
	logic         adv;

	logic signed [RAW_W-1:0]  raw_x;
	logic signed [RAW_W-1:0]  raw_y;
	logic signed [BASE_W-1:0] base_x;
	logic signed [BASE_W-1:0] base_y;
	logic [DZ_W-1:0]          dz_in;
	logic [RAW_W-1:0]         ax_in;
	logic [RAW_W-1:0]         ay_in;

	logic [31:0]             px_s1;
	logic [31:0]             py_s1;
	logic [2*DZ_W-1:0]       dz2_s1;
	logic [31:0]             s_s2;
	sq_t                     sq_w [SQ_STEPS+1];
	logic [MAG_W-1:0]        mag;
	logic [MAG_W-1:0]        over;
	logic [DZ_W-1:0]         span;
	logic                    clamp;
	logic [MAG_W-1:0]        m_sa;
	logic [MAG_W-2:0]        ov_sa;
	logic [DZ_W-1:0]         sp_sa;
	logic [DEN_W-1:0]        nx_sb;
	logic [DEN_W-1:0]        ny_sb;
	logic [DEN_W-1:0]        den_sb;
	logic [NW-1:0]           rnd_x;
	logic [NW-1:0]           rnd_y;

	logic [DEN_W-1:0] den_w   [QW+1];
	logic [DEN_W-1:0] rem_x_w [QW+1];
	logic [DEN_W-1:0] rem_y_w [QW+1];
	logic [QW-1:0]    low_x_w [QW+1];
	logic [QW-1:0]    low_y_w [QW+1];
	logic [QW-1:0]    q_x_w   [QW+1];
	logic [QW-1:0]    q_y_w   [QW+1];

	logic signed [SW-1:0]     vx;
	logic signed [SW-1:0]     vy;
	logic signed [SW-1:0]     sum_x;
	logic signed [SW-1:0]     sum_y;
	logic signed [BASE_W-1:0] fin_x;
	logic signed [BASE_W-1:0] fin_y;
	logic                     fin_defl;

	logic signed [BASE_W-1:0] out_x_q;
	logic signed [BASE_W-1:0] out_y_q;
	logic                     out_defl_q;
	logic                     out_sel_q;
	logic                     out_en_q;

	// Dead-zone registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q  <= LEFT_DZ_RST;
			right_dz_q <= RIGHT_DZ_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LEFT_DZ:  left_dz_q  <= cfg_wdata;
				REG_RIGHT_DZ: right_dz_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Flow control: the chain moves unless a held result would be overwritten.
	assign out_hold = out_vld_q && !m_tready;
	assign adv      = !out_hold || !vld_q[LAST];
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[P-2:0], s_tvalid};
			end
			if (!out_hold) begin
				out_vld_q <= vld_q[LAST];
			end
		end
	end

	// Unpack the input transfer.
	always_comb begin
		raw_x  = s_tdata[15:0];
		raw_y  = s_tdata[31:16];
		base_x = s_tdata[50:32];
		base_y = s_tdata[69:51];
		dz_in  = s_tuser[0] ? right_dz_q : left_dz_q;
		ax_in  = raw_x[RAW_W-1] ? RAW_W'(-raw_x) : RAW_W'(raw_x);
		ay_in  = raw_y[RAW_W-1] ? RAW_W'(-raw_y) : RAW_W'(raw_y);
	end

	// Second-stage side data, carrying the zone test result.
	always_comb begin
		cr1_d         = cr_q[0];
		cr1_d.outside = ((px_s1 + py_s1) > {2'b00, dz2_s1});
	end

	// Side data shift line, with the zone test resolved in the second stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			cr_q[0].bx      <= base_x;
			cr_q[0].by      <= base_y;
			cr_q[0].sel     <= s_tuser[0];
			cr_q[0].en      <= s_tuser[1];
			cr_q[0].neg_x   <= raw_x[RAW_W-1];
			cr_q[0].neg_y   <= raw_y[RAW_W-1];
			cr_q[0].outside <= 1'b0;
			cr_q[0].dz      <= dz_in;
			cr_q[0].ax      <= ax_in;
			cr_q[0].ay      <= ay_in;
			cr_q[1]         <= cr1_d;
			for (int k = 2; k < P; k++) begin
				cr_q[k] <= cr_q[k-1];
			end
		end
	end

	// Squares and the magnitude sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1  <= ax_in * ax_in;
			py_s1  <= ay_in * ay_in;
			dz2_s1 <= dz_in * dz_in;
			s_s2   <= px_s1 + py_s1;
		end
	end

	// Square root chain on the sum scaled by 2^16.
	assign sq_w[0] = '{n: {s_s2, 16'h0000}, rem: '0, root: '0};

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		srdz_sqrt_cell u_cell (
			.clk  (clk),
			.adv  (adv),
			.sq_i (sq_w[i]),
			.sq_o (sq_w[i+1])
		);
	end

	// Scale terms: distance past the zone edge, clamped at full deflection.
	always_comb begin
		mag   = sq_w[SQ_STEPS].root;
		over  = mag - {1'b0, cr_q[25].dz, 8'h00};
		span  = FULL_SCALE - cr_q[25].dz;
		clamp = (over >= {1'b0, span, 8'h00});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_sa   <= mag;
			ov_sa  <= clamp ? (MAG_W-1)'(256) : over[MAG_W-2:0];
			sp_sa  <= clamp ? DZ_W'(1) : span;
			nx_sb  <= cr_q[26].ax * ov_sa;
			ny_sb  <= cr_q[26].ay * ov_sa;
			den_sb <= m_sa * sp_sa;
		end
	end

	// Rounded dividends and the first divider state.
	always_comb begin
		rnd_x = (NW'(nx_sb) << FRAC_BITS) + NW'(den_sb >> 1);
		rnd_y = (NW'(ny_sb) << FRAC_BITS) + NW'(den_sb >> 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_w[0]   <= den_sb;
			rem_x_w[0] <= rnd_x[NW-1:QW];
			rem_y_w[0] <= rnd_y[NW-1:QW];
			low_x_w[0] <= rnd_x[QW-1:0];
			low_y_w[0] <= rnd_y[QW-1:0];
			q_x_w[0]   <= '0;
			q_y_w[0]   <= '0;
		end
	end

	// Divider chain, one quotient bit per cell.
	for (genvar j = 0; j < QW; j++) begin : g_div
		srdz_div_cell #(.QW(QW)) u_cell (
			.clk     (clk),
			.adv     (adv),
			.den_i   (den_w[j]),
			.rem_x_i (rem_x_w[j]),
			.rem_y_i (rem_y_w[j]),
			.low_x_i (low_x_w[j]),
			.low_y_i (low_y_w[j]),
			.q_x_i   (q_x_w[j]),
			.q_y_i   (q_y_w[j]),
			.den_o   (den_w[j+1]),
			.rem_x_o (rem_x_w[j+1]),
			.rem_y_o (rem_y_w[j+1]),
			.low_x_o (low_x_w[j+1]),
			.low_y_o (low_y_w[j+1]),
			.q_x_o   (q_x_w[j+1]),
			.q_y_o   (q_y_w[j+1])
		);
	end

	// Sign, base merge and saturation.
	always_comb begin
		vx = {{(SW-QW){1'b0}}, q_x_w[QW]};
		vy = {{(SW-QW){1'b0}}, q_y_w[QW]};
		if (cr_q[LAST].neg_x) begin
			vx = -vx;
		end
		if (cr_q[LAST].neg_y) begin
			vy = -vy;
		end
		sum_x = vx;
		sum_y = vy;
		if (cr_q[LAST].sel) begin
			sum_x = vx + {{(SW-BASE_W){cr_q[LAST].bx[BASE_W-1]}}, cr_q[LAST].bx};
			sum_y = vy + {{(SW-BASE_W){cr_q[LAST].by[BASE_W-1]}}, cr_q[LAST].by};
		end
		fin_defl = cr_q[LAST].en && cr_q[LAST].outside;
		fin_x    = cr_q[LAST].bx;
		fin_y    = cr_q[LAST].by;
		if (fin_defl) begin
			fin_x = (sum_x > SAT_HI) ? BASE_W'(OUT_MAX) :
				(sum_x < SAT_LO) ? BASE_W'(OUT_MIN) : sum_x[BASE_W-1:0];
			fin_y = (sum_y > SAT_HI) ? BASE_W'(OUT_MAX) :
				(sum_y < SAT_LO) ? BASE_W'(OUT_MIN) : sum_y[BASE_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (!out_hold) begin
			out_x_q    <= fin_x;
			out_y_q    <= fin_y;
			out_defl_q <= fin_defl;
			out_sel_q  <= cr_q[LAST].sel;
			out_en_q   <= cr_q[LAST].en;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = {2'b00, out_y_q, out_x_q};
	assign m_tuser[0] = out_defl_q;

	`include "stick_radial_dead_zone_macros.svh"

	`SRDZ_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && vld_q[LAST], "input stalled without a blocked result")
	`SRDZ_ASSERT_NXT(a_deliver, vld_q[LAST] && !out_hold, m_tvalid, "finished item did not reach the output")
	`SRDZ_ASSERT_IMP(a_defl_en, m_tvalid && out_defl_q, out_en_q, "deflected set while stick disabled")
	`SRDZ_ASSERT_IMP(a_move_unit, m_tvalid && out_defl_q && !out_sel_q, (out_x_q <= ONE_Q) && (out_x_q >= -ONE_Q), "movement vector exceeds unit length")

endmodule

`default_nettype wire
